[src/ibbh_pkg.sv]
// ----------------------------------------------------------------------------
// ibbh_pkg
// Shared types, operation codes and mixing functions for the incremental
// byte hash.
// ----------------------------------------------------------------------------
package ibbh_pkg;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [31:0] TAIL_MUL  = 32'hA5A5A5A5;
  localparam int unsigned PEND_DEPTH = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_C
  } ibbh_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic push;
    logic restart;
    logic fin_load;
    logic fin_a;
    logic fin_b;
    logic fin_c;
  } ibbh_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } ibbh_stat_t;

  // Additive mix: h ^ ~((h << 11) + (v ^ (h >> 5)))
  function automatic logic [31:0] mix_a(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] sum;
    sum   = (h << 11) + (v ^ (h >> 5));
    mix_a = h ^ ~sum;
  endfunction

  // Multiplicative mix: h ^ (h << 7) ^ (v * (h >> 3)), modulo 2^32
  function automatic logic [31:0] mix_b(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] prod;
    prod  = v * (h >> 3);
    mix_b = h ^ (h << 7) ^ prod;
  endfunction

endpackage

[src/ibbh_ctrl.sv]
// ----------------------------------------------------------------------------
// ibbh_ctrl
// Controller: accepts transfers in idle and sequences the three finalize
// steps of a read.
// ----------------------------------------------------------------------------
module ibbh_ctrl
  import ibbh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  ibbh_stat_t stat,
  output ibbh_cmd_t  cmd
);

  ibbh_state_t state;
  ibbh_state_t state_next;
  logic        accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_PUSH:    cmd.push    = 1'b1;
            OP_RESTART: cmd.restart = 1'b1;
            OP_READ: begin
              cmd.fin_load = 1'b1;
              state_next   = ST_FIN_A;
            end
            default: ;
          endcase
        end
      end
      ST_FIN_A: begin
        cmd.fin_a  = 1'b1;
        state_next = ST_FIN_B;
      end
      ST_FIN_B: begin
        cmd.fin_b  = 1'b1;
        state_next = ST_FIN_C;
      end
      ST_FIN_C: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.fin_c  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[src/ibbh_dp.sv]
// ----------------------------------------------------------------------------
// ibbh_dp
// Datapath: seed, running hash, pending bytes, finalize register and the
// output register.
// ----------------------------------------------------------------------------
module ibbh_dp
  import ibbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic [7:0]  in_byte,
  input  ibbh_cmd_t   cmd,
  output ibbh_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest
);

  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [31:0] running_hash_next;
  logic [7:0]  pend [PEND_DEPTH];
  logic [2:0]  pend_count;
  logic [31:0] fin_hash;
  logic [31:0] blk_v1;
  logic [31:0] blk_v2;
  logic [31:0] fin_v1;
  logic [31:0] fin_w;
  logic [31:0] fin_b_hash;
  logic [7:0]  tail_byte;
  logic [1:0]  tail_loop;
  logic [31:0] tail_prod;
  logic [31:0] tail_hash;
  logic        hi_half;
  logic [1:0]  rem;

  assign stat.out_busy = out_valid && !out_ready;

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_wr_en) begin
      seed <= seed_wr_data;
    end
  end

  // Block mix on the eighth byte, taken straight from the input; both
  // halves work on the hash as it stood before the block
  assign blk_v1 = {pend[0], pend[1], pend[2], pend[3]};
  assign blk_v2 = {pend[4], pend[5], pend[6], in_byte};
  assign running_hash_next = mix_b(running_hash, blk_v1) ^ mix_a(running_hash, blk_v2)
                             ^ running_hash;

  // Running hash and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      pend_count   <= '0;
    end else if (cmd.restart) begin
      running_hash <= seed;
      pend_count   <= '0;
    end else if (cmd.push) begin
      if (pend_count == 3'(PEND_DEPTH)) begin
        running_hash <= running_hash_next;
        pend_count   <= '0;
      end else begin
        pend_count <= pend_count + 3'd1;
      end
    end
  end

  // Store a pushed byte at the fill position
  always_ff @(posedge clk) begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      if (cmd.push && pend_count == 3'(i)) begin
        pend[i] <= in_byte;
      end
    end
  end

  // Tail selection: upper half in play once four or more bytes are pending
  assign hi_half   = pend_count[2];
  assign rem       = pend_count[1:0];
  assign fin_v1    = {pend[0], pend[1], pend[2], pend[3]};
  assign fin_w     = hi_half ? {16'd0, pend[4], pend[5]} : {16'd0, pend[0], pend[1]};
  assign fin_b_hash = hi_half ? mix_b(fin_hash, fin_w) : mix_a(fin_hash, fin_w);
  assign tail_byte = rem[1] ? (hi_half ? pend[6] : pend[2])
                            : (hi_half ? pend[4] : pend[0]);
  assign tail_loop = {1'b0, hi_half} + {1'b0, (rem == 2'd3)};
  assign tail_prod = fin_hash * TAIL_MUL;
  assign tail_hash = fin_hash + (({24'd0, tail_byte} ^ tail_prod) + {30'd0, tail_loop});

  // Finalize register: advance one step per command
  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      fin_hash <= running_hash;
    end else if (cmd.fin_a && hi_half) begin
      fin_hash <= mix_a(fin_hash, fin_v1);
    end else if (cmd.fin_b && rem[1]) begin
      fin_hash <= fin_b_hash;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_c) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_c) begin
      out_digest <= rem[0] ? tail_hash : fin_hash;
    end
  end

endmodule

[src/incremental_bloom_byte_hash.sv]
// ----------------------------------------------------------------------------
// incremental_bloom_byte_hash
// Seeded incremental 32-bit byte hash for Bloom filter indexing.
// ----------------------------------------------------------------------------
// A push (tuser 0) of the eighth byte of a block does its two-word mix in
// the accepting cycle, so bytes stream at one per clock while no read is
// being finalized. A restart (tuser 2) reloads the seed; a seed write takes
// effect at the next restart. In a read (tuser 1) the accepting cycle copies
// the hash, then a four-byte step and a two/three-byte step act on the
// finalize register and the single-byte tail step loads the output register;
// the tail step waits while the output register still holds an untaken
// digest. The read leaves the pending bytes in place. Code 3 is accepted and
// ignored.
module incremental_bloom_byte_hash
  import ibbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [31:0] digest
);

  ibbh_cmd_t  cmd;
  ibbh_stat_t stat;

  ibbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ibbh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .in_byte      (s_axis_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_digest   (m_axis_tdata)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seeded incremental byte hash. Push, read,
// restart and unused-code transfers go in with random gaps while idling is on. A tracker keeps
// its own copy of the seed, the chained hash and the partial block, and
// works out the digest that each read must produce. Each digest that leaves
// the block is compared in order with the oldest one still due.
// ----------------------------------------------------------------------------

// Digest tracker: own copy of the hash state, and the digests still due
class byte_hash_tracker;
  logic [31:0] seed_val;
  logic [31:0] chain_hash;
  logic [7:0]  part_bytes [7];
  int unsigned part_count;
  logic [31:0] digests_due [$];
  int unsigned errors;

  function new();
    seed_val   = '0;
    chain_hash = '0;
    part_count = 0;
    errors     = 0;
    foreach (part_bytes[i]) part_bytes[i] = '0;
  endfunction

  function void load_seed(input logic [31:0] v);
    seed_val = v;
  endfunction

  function int unsigned outstanding();
    return digests_due.size();
  endfunction

  // h xor not((h << 11) + (v xor (h >> 5)))
  function logic [31:0] add_round(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] acc;
    acc = {h[20:0], 11'b0} + (v ^ {5'b0, h[31:5]});
    return h ^ ~acc;
  endfunction

  // h xor (h << 7) xor (v * (h >> 3)), all modulo 2^32
  function logic [31:0] mul_round(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] prod;
    prod = v * {3'b0, h[31:3]};
    return h ^ {h[24:0], 7'b0} ^ prod;
  endfunction

  // Finish a copy of the hash over the partial block, leaving it in place
  function logic [31:0] peek_digest();
    logic [31:0] h;
    logic [31:0] w1;
    logic [31:0] w2;
    int unsigned left;
    int unsigned rounds;
    h      = chain_hash;
    w1     = '0;
    w2     = '0;
    rounds = 0;
    left   = part_count;
    for (int i = 0; i < part_count; i++) begin
      if (i < 4) w1 = {w1[23:0], part_bytes[i]};
      else       w2 = {w2[23:0], part_bytes[i]};
    end
    if (left == 0) return h;
    // four-byte step
    if (left >= 4) begin
      h      = add_round(h, w1);
      rounds = 1;
      left   = left - 4;
      w1     = w2;
    end
    // three- or two-byte step
    if (left == 3) begin
      h      = (rounds != 0) ? mul_round(h, w1 >> 8) : add_round(h, w1 >> 8);
      rounds = rounds + 1;
      left   = 1;
      w1     = w1 & 32'h0000_00FF;
    end else if (left == 2) begin
      h    = (rounds != 0) ? mul_round(h, w1) : add_round(h, w1);
      left = 0;
    end
    // single-byte tail
    if (left > 0) h = h + ((w1 ^ (h * ibbh_pkg::TAIL_MUL)) + rounds[31:0]);
    return h;
  endfunction

  // Hold a byte, or mix a full block of eight into the chain
  function void take_byte(input logic [7:0] b);
    logic [31:0] hi_word;
    logic [31:0] lo_word;
    logic [31:0] h;
    logic [31:0] acc;
    if (part_count < 7) begin
      part_bytes[part_count] = b;
      part_count = part_count + 1;
      return;
    end
    hi_word = {part_bytes[0], part_bytes[1], part_bytes[2], part_bytes[3]};
    lo_word = {part_bytes[4], part_bytes[5], part_bytes[6], b};
    h   = chain_hash;
    acc = {h[20:0], 11'b0} + (lo_word ^ {5'b0, h[31:5]});
    chain_hash = h ^ {h[24:0], 7'b0} ^ (hi_word * {3'b0, h[31:3]}) ^ ~acc;
    part_count = 0;
  endfunction

  // Apply one accepted input transfer
  function void note_transfer(input logic [1:0] op, input logic [7:0] b);
    case (op)
      ibbh_pkg::OP_PUSH: begin
        take_byte(b);
      end
      ibbh_pkg::OP_READ: begin
        digests_due.push_back(peek_digest());
      end
      ibbh_pkg::OP_RESTART: begin
        chain_hash = seed_val;
        part_count = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Compare one accepted output transfer with the oldest digest due
  function void check_digest(input logic [31:0] got);
    logic [31:0] want;
    if (digests_due.size() == 0) begin
      $display("%0t: unexpected digest, expected none, actual %08h", $time, got);
      errors++;
      return;
    end
    want = digests_due.pop_front();
    if (got !== want) begin
      $display("%0t: digest mismatch, expected %08h, actual %08h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ibbh_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned BURST_LEN   = 315;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        seed_wr_en    = 1'b0;
  logic [31:0] seed_wr_data  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] digest

  logic        idling_on     = 1'b1;
  int unsigned stall_cycles  = 0;

  byte_hash_tracker tracker = new();

  incremental_bloom_byte_hash uut (
    .clk           (clk),
    .rst           (rst),
    .seed_wr_en    (seed_wr_en),
    .seed_wr_data  (seed_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Stall the digest side at random while idling is on
  always @(posedge clk) begin
    m_axis_tready <= !idling_on || ($urandom_range(0, 99) >= 30);
  end

  // Record transfers on both sides; input first
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_transfer(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_digest(m_axis_tdata);
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL incremental_bloom_byte_hash");
        $finish;
      end
    end
  end

  // Offer one item, with random gaps ahead of it, and hold until taken
  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    while (idling_on && ($urandom_range(0, 99) < 30)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid and hold until every digest due has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Write the seed once the block has gone idle
  task automatic write_seed(input logic [31:0] v);
    drain();
    repeat (8) @(posedge clk);
    seed_wr_en   <= 1'b1;
    seed_wr_data <= v;
    @(posedge clk);
    seed_wr_en   <= 1'b0;
    tracker.load_seed(v);
  endtask

  // Mostly pushes, with reads, restarts and the unused code mixed in
  task automatic random_burst(input int unsigned count);
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 78)      send_op(OP_PUSH, 8'($urandom));
      else if (pick < 93) send_op(OP_READ, 8'($urandom));
      else if (pick < 97) send_op(OP_RESTART, 8'($urandom));
      else                send_op(OP_UNUSED, 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] seeds [5];
    seeds[0] = 32'hFFFF_FFFF;
    seeds[1] = 32'h0000_0000;
    seeds[2] = $urandom;
    seeds[3] = 32'h8000_0001;
    seeds[4] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty read, every tail length, a full block, unused code
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'hFF);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'h00);
    send_op(OP_READ, 8'hFF);
    send_op(OP_PUSH, 8'hA5);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'h5A);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'h80);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'h01);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'h7F);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'hFE);
    send_op(OP_READ, 8'h00);
    send_op(OP_UNUSED, 8'hFF);
    send_op(OP_READ, 8'h00);
    send_op(OP_RESTART, 8'hFF);
    send_op(OP_READ, 8'h00);
    send_op(OP_PUSH, 8'hFF);
    send_op(OP_PUSH, 8'hFF);
    send_op(OP_READ, 8'h00);

    // Seed phases: the first read shows the old chain until the restart
    for (int p = 0; p < 5; p++) begin
      write_seed(seeds[p]);
      idling_on <= (p != 2);
      send_op(OP_READ, 8'h00);
      send_op(OP_RESTART, 8'h00);
      random_burst(BURST_LEN);
    end

    // Let the last digests out, then allow the block to settle
    drain();
    repeat (16) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("PASS incremental_bloom_byte_hash");
    end else begin
      $display("FAIL incremental_bloom_byte_hash");
    end
    $finish;
  end

endmodule
